/* hdl/pnsb_pkg.sv */
// Package: shared types, constants and helpers for the BLAKE2b nonce search block.
package pnsb_pkg;

    localparam int MIX_ROUNDS_DEF = 32;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DAG_W0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAG_W1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAG_W2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAG_W3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LANES  = 3'd4;

    typedef logic [15:0][63:0] t_blk;
    typedef logic [7:0][63:0]  t_dig;

    typedef struct packed {
        logic [63:0] message_w0;
        logic [63:0] message_w1;
        logic [63:0] message_w2;
        logic [63:0] message_w3;
        logic [63:0] block_height;
        logic [63:0] target_w0;
        logic [63:0] target_w1;
        logic [63:0] target_w2;
        logic [63:0] target_w3;
        logic [63:0] start_nonce;
        logic [63:0] max_tries;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [63:0] found_nonce;
        logic [63:0] hash_w0;
        logic [63:0] hash_w1;
        logic [63:0] hash_w2;
        logic [63:0] hash_w3;
    } t_out;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [3:0] SIGMA [12][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd14, 4'd9, 4'd3, 4'd12, 4'd13, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}
    };

    // four little-endian words -> 256-bit number, byte 0 most significant
    function automatic logic [255:0] be256(input logic [3:0][63:0] w);
        logic [255:0] r;
        r = '0;
        for (int b = 0; b < 32; b++) begin
            r[255-8*b -: 8] = w[b/8][8*(b%8) +: 8];
        end
        return r;
    endfunction

endpackage

/* hdl/pnsb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pnsb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

/* hdl/pnsb_mod.sv */
// Bit-serial 32-bit remainder unit, one quotient bit per cycle.
module pnsb_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_dvd;
    logic [31:0] r_div;
    logic [32:0] t;
    logic [31:0] n_rem;

    always_comb begin
        t = {r_rem, r_dvd[31]};
        if (t >= {1'b0, r_div}) begin
            n_rem = 32'(t - {1'b0, r_div});
        end else begin
            n_rem = t[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[30:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

/* hdl/pnsb_blake2b.sv */
// Iterative single-block BLAKE2b compression core, one half G function per cycle.
module pnsb_blake2b
    import pnsb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_blk       i_blk,
    input  logic [7:0] i_len,
    input  logic [6:0] i_outlen,
    output logic       o_done,
    output t_dig       o_dig
);
    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_LOAD = 5'b00010,
        C_PREP = 5'b00100,
        C_RUN  = 5'b01000,
        C_FIN  = 5'b10000
    } t_cstate;

    t_cstate     r_state;
    logic [3:0]  r_ld;
    logic [3:0]  r_rnd;
    logic [2:0]  r_g;
    logic        r_half;
    logic        r_done;
    logic [63:0] r_h0;
    logic [63:0] r_v [16];
    t_dig        r_dig;

    logic [63:0] n_v [16];
    logic [63:0] t_v [16];
    logic [63:0] a1, c1, d1, b1, dx, bx;
    logic [1:0]  amt;
    logic [1:0]  col;
    logic [3:0]  raddr;
    logic [63:0] ram_q;

    pnsb_ram #(.WIDTH(64), .DEPTH(16)) u_msg (
        .i_clk  (i_clk),
        .i_we   (r_state == C_LOAD),
        .i_waddr(r_ld),
        .i_wdata(i_blk[r_ld]),
        .i_raddr(raddr),
        .o_rdata(ram_q)
    );

    always_comb begin
        raddr = '0;
        if (r_state == C_PREP) begin
            raddr = SIGMA[0][0];
        end else if (r_state == C_RUN) begin
            if (!r_half) begin
                raddr = SIGMA[r_rnd][{r_g, 1'b1}];
            end else if (r_g != 3'd7) begin
                raddr = SIGMA[r_rnd][{3'(r_g + 3'd1), 1'b0}];
            end else if (r_rnd != 4'd11) begin
                raddr = SIGMA[4'(r_rnd + 4'd1)][0];
            end
        end
    end

    // G always works on column 0; rows rotate after each G (diagonal on g 3, back on g 7)
    always_comb begin
        t_v = r_v;
        a1  = r_v[0] + r_v[4] + ram_q;
        dx  = r_v[12] ^ a1;
        d1  = r_half ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
        c1  = r_v[8] + d1;
        bx  = r_v[4] ^ c1;
        b1  = r_half ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
        t_v[0]  = a1;
        t_v[4]  = b1;
        t_v[8]  = c1;
        t_v[12] = d1;
        n_v = t_v;
        amt = 2'd1;
        col = 2'd0;
        if (r_half) begin
            for (int k = 0; k < 4; k++) begin
                case (r_g)
                    3'd3:    amt = 2'(1 + k);
                    3'd7:    amt = 2'(1 - k);
                    default: amt = 2'd1;
                endcase
                for (int j = 0; j < 4; j++) begin
                    col = 2'(j) + amt;
                    n_v[4*k+j] = t_v[4*k+int'(col)];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_ld    <= '0;
            r_rnd   <= '0;
            r_g     <= '0;
            r_half  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_state <= C_LOAD;
                        r_ld    <= '0;
                    end
                end
                C_LOAD: begin
                    r_ld <= r_ld + 4'd1;
                    if (r_ld == 4'd15) begin
                        r_state <= C_PREP;
                    end
                end
                C_PREP: begin
                    r_state <= C_RUN;
                    r_rnd   <= '0;
                    r_g     <= '0;
                    r_half  <= 1'b0;
                end
                C_RUN: begin
                    r_half <= ~r_half;
                    if (r_half) begin
                        r_g <= r_g + 3'd1;
                        if (r_g == 3'd7) begin
                            r_rnd <= r_rnd + 4'd1;
                            if (r_rnd == 4'd11) begin
                                r_state <= C_FIN;
                            end
                        end
                    end
                end
                C_FIN: begin
                    r_state <= C_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_h0 <= IV[0] ^ 64'h0000_0000_0101_0000 ^ {57'd0, i_outlen};
            r_v[0] <= IV[0] ^ 64'h0000_0000_0101_0000 ^ {57'd0, i_outlen};
            for (int i = 1; i < 8; i++) begin
                r_v[i] <= IV[i];
            end
            for (int i = 8; i < 16; i++) begin
                if (i == 12) begin
                    r_v[i] <= IV[4] ^ {56'd0, i_len};
                end else if (i == 14) begin
                    r_v[i] <= ~IV[6];
                end else begin
                    r_v[i] <= IV[i-8];
                end
            end
        end else if (r_state == C_RUN) begin
            r_v <= n_v;
        end
        if (r_state == C_FIN) begin
            r_dig[0] <= r_h0 ^ r_v[0] ^ r_v[8];
            for (int i = 1; i < 8; i++) begin
                r_dig[i] <= IV[i] ^ r_v[i] ^ r_v[i+8];
            end
        end
    end

    assign o_done = r_done;
    assign o_dig  = r_dig;
endmodule

/* hdl/pow_nonce_search_blake2b.sv */
// Top level: request sequencer for the BLAKE2b nonce search over a shared compression core.
// Throughput: one request at a time; the next is taken once the result has been taken.
// Reset (i_rst_n low, synchronous): idle, no result pending, DAG seed 0, lane count 1.
module pow_nonce_search_blake2b
    import pnsb_pkg::*;
#(
    parameter int MIX_ROUNDS = MIX_ROUNDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);
    localparam int RND_W = $clog2(MIX_ROUNDS + 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_SEED = 10'b00_0000_0010,
        S_CHK  = 10'b00_0000_0100,
        S_LANE = 10'b00_0000_1000,
        S_MOD  = 10'b00_0001_0000,
        S_DAG  = 10'b00_0010_0000,
        S_BASE = 10'b00_0100_0000,
        S_ACCH = 10'b00_1000_0000,
        S_FIN  = 10'b01_0000_0000,
        S_CMP  = 10'b10_0000_0000
    } t_state;

    t_state           r_state;
    logic             r_go;
    logic             r_out_valid;
    t_out             r_out;
    logic [3:0][63:0] r_dag;
    logic [31:0]      r_lanes;
    logic [3:0][63:0] r_msg;
    logic [3:0][63:0] r_tgt;
    logic [63:0]      r_height;
    logic [63:0]      r_nonce;
    logic [63:0]      r_tries;
    logic [3:0][63:0] r_seed;
    logic [3:0][63:0] r_acc;
    logic [3:0][63:0] r_base;
    logic [3:0][63:0] r_acch;
    logic [3:0][63:0] r_hash;
    logic [RND_W-1:0] r_rnd;
    logic [31:0]      r_lane;
    logic [31:0]      r_raw;

    t_blk        blk;
    logic [7:0]  len;
    logic [6:0]  outlen;
    logic        hash_st;
    logic        core_start;
    logic        core_done;
    t_dig        dig;
    logic        mod_done;
    logic [31:0] mod_rem;
    logic        in_acc;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;
    assign hash_st    = (r_state == S_SEED) || (r_state == S_LANE) || (r_state == S_DAG) ||
                        (r_state == S_BASE) || (r_state == S_ACCH) || (r_state == S_FIN);
    assign core_start = hash_st && !r_go;

    always_comb begin
        blk    = '0;
        len    = 8'd32;
        outlen = 7'd32;
        case (r_state)
            S_SEED: blk[3:0] = r_msg;
            S_LANE: begin
                blk[3:0] = r_seed;
                blk[4]   = r_nonce;
                blk[5]   = r_height;
                blk[6]   = 64'(r_rnd);
                len      = 8'd52;
            end
            S_DAG: begin
                blk[3:0] = r_dag;
                blk[4]   = {33'd0, r_lane[31:1]};
                len      = 8'd40;
                outlen   = 7'd64;
            end
            S_BASE: begin
                blk[3:0] = r_seed;
                blk[7:4] = r_msg;
                blk[8]   = r_nonce;
                blk[9]   = r_height;
                len      = 8'd80;
            end
            S_ACCH: blk[3:0] = r_acc;
            S_FIN: begin
                blk[3:0] = r_base;
                blk[7:4] = r_acch;
                blk[8]   = r_nonce;
                blk[9]   = r_height;
                len      = 8'd80;
            end
            default: blk = '0;
        endcase
    end

    pnsb_blake2b u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_blk   (blk),
        .i_len   (len),
        .i_outlen(outlen),
        .o_done  (core_done),
        .o_dig   (dig)
    );

    pnsb_mod u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   ((r_state == S_MOD) && !r_go),
        .i_dividend(r_raw),
        .i_divisor (r_lanes),
        .o_done    (mod_done),
        .o_rem     (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dag   <= '0;
            r_lanes <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DAG_W0: r_dag[0] <= i_cfg_data;
                CFG_DAG_W1: r_dag[1] <= i_cfg_data;
                CFG_DAG_W2: r_dag[2] <= i_cfg_data;
                CFG_DAG_W3: r_dag[3] <= i_cfg_data;
                CFG_LANES:  r_lanes  <= i_cfg_data[31:0];
                default:    r_lanes  <= r_lanes;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if ((hash_st || r_state == S_MOD) && !r_go) begin
                r_go <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_SEED;
                    end
                end
                S_SEED: begin
                    if (r_go && core_done) begin
                        r_go    <= 1'b0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_tries == 64'd0) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_LANE;
                    end
                end
                S_LANE: begin
                    if (r_go && core_done) begin
                        r_go    <= 1'b0;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_go && mod_done) begin
                        r_go    <= 1'b0;
                        r_state <= S_DAG;
                    end
                end
                S_DAG: begin
                    if (r_go && core_done) begin
                        r_go    <= 1'b0;
                        r_state <= (r_rnd == RND_W'(MIX_ROUNDS - 1)) ? S_BASE : S_LANE;
                    end
                end
                S_BASE: begin
                    if (r_go && core_done) begin
                        r_go    <= 1'b0;
                        r_state <= S_ACCH;
                    end
                end
                S_ACCH: begin
                    if (r_go && core_done) begin
                        r_go    <= 1'b0;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_go && core_done) begin
                        r_go    <= 1'b0;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (be256(r_hash) <= be256(r_tgt)) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_msg    <= {i_in_data.message_w3, i_in_data.message_w2,
                                 i_in_data.message_w1, i_in_data.message_w0};
                    r_tgt    <= {i_in_data.target_w3, i_in_data.target_w2,
                                 i_in_data.target_w1, i_in_data.target_w0};
                    r_height <= i_in_data.block_height;
                    r_nonce  <= i_in_data.start_nonce;
                    r_tries  <= i_in_data.max_tries;
                    r_hash   <= '0;
                end
            end
            S_SEED: begin
                if (r_go && core_done) begin
                    r_seed <= dig[3:0];
                    if (r_lanes == 32'd0) begin
                        r_nonce <= r_nonce + r_tries;
                        r_tries <= '0;
                    end
                end
            end
            S_CHK: begin
                r_rnd <= '0;
                r_acc <= '0;
                if (r_tries == 64'd0) begin
                    r_out.found       <= 1'b0;
                    r_out.found_nonce <= r_nonce;
                    r_out.hash_w0     <= r_hash[0];
                    r_out.hash_w1     <= r_hash[1];
                    r_out.hash_w2     <= r_hash[2];
                    r_out.hash_w3     <= r_hash[3];
                end
            end
            S_LANE: begin
                if (r_go && core_done) begin
                    r_raw <= dig[0][31:0];
                end
            end
            S_MOD: begin
                if (r_go && mod_done) begin
                    r_lane <= mod_rem;
                end
            end
            S_DAG: begin
                if (r_go && core_done) begin
                    r_acc <= r_acc ^ (r_lane[0] ? dig[7:4] : dig[3:0]);
                    r_rnd <= RND_W'(r_rnd + 1'b1);
                end
            end
            S_BASE: begin
                if (r_go && core_done) begin
                    r_base <= dig[3:0];
                end
            end
            S_ACCH: begin
                if (r_go && core_done) begin
                    r_acch <= dig[3:0];
                end
            end
            S_FIN: begin
                if (r_go && core_done) begin
                    r_hash  <= dig[3:0];
                    r_tries <= r_tries - 64'd1;
                end
            end
            S_CMP: begin
                if (be256(r_hash) <= be256(r_tgt)) begin
                    r_out.found       <= 1'b1;
                    r_out.found_nonce <= r_nonce;
                    r_out.hash_w0     <= r_hash[0];
                    r_out.hash_w1     <= r_hash[1];
                    r_out.hash_w2     <= r_hash[2];
                    r_out.hash_w3     <= r_hash[3];
                end else begin
                    r_nonce <= r_nonce + 64'd1;
                end
            end
            default: r_rnd <= r_rnd;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_IDLE))
        else $error("result pending while search runs");

    a_core_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_done |-> (hash_st && r_go))
        else $error("compression finished outside a hash step");

    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && r_go && mod_done) |=> (r_lane < r_lanes))
        else $error("lane index not below lane count");

    a_no_tries_no_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LANE) |-> (r_tries != 64'd0 && r_lanes != 32'd0))
        else $error("mixing started without tries or lanes");
endmodule

/* tb/sv/tb_pow_nonce_search_blake2b.sv */
// Testbench: BLAKE2b nonce search block, directed table plus random requests checked by a predictor.
`timescale 1ns / 100ps

module tb_pow_nonce_search_blake2b;
    import pnsb_pkg::*;

    localparam int          LIMIT       = 40_000_000;
    localparam int          HOLD_CYCLES = 3000;
    localparam logic [2:0]  CFG_IDX_MAX = '1;

    typedef struct {
        t_in         req;
        logic [31:0] lanes;
        bit          typed;
        t_out        res;
    } t_row;

    typedef struct {
        bit   typed;
        t_out res;
    } t_tag;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    t_out        o_out_data;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    pow_nonce_search_blake2b dut (.*);

    always #4 i_clk = ~i_clk;

    // model copy of the configuration
    logic [3:0][63:0] dag_seed_q;
    logic [31:0]      lane_cnt_q;

    t_out  expected_results[$];
    t_tag  request_tags[$];
    int    errors = 0;
    int    cycles = 0;
    int    n_found = 0;
    int    n_results = 0;
    bit    quiet = 0;
    bit    hold_req = 0;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [7:0][63:0] b2b_block(input logic [15:0][63:0] m, input int len,
                                                   input int outlen);
        int ga[8] = '{0, 1, 2, 3, 0, 1, 2, 3};
        int gb[8] = '{4, 5, 6, 7, 5, 6, 7, 4};
        int gc[8] = '{8, 9, 10, 11, 10, 11, 8, 9};
        int gd[8] = '{12, 13, 14, 15, 15, 12, 13, 14};
        logic [15:0][63:0] v;
        logic [7:0][63:0]  h;
        logic [63:0]       x, y;
        int a, b, c, d;
        for (int i = 0; i < 8; i++) h[i] = IV[i];
        h[0] ^= 64'h01010000 ^ 64'(outlen);
        for (int i = 0; i < 8; i++) begin
            v[i]   = h[i];
            v[i+8] = IV[i];
        end
        v[12] ^= 64'(len);
        v[14] = ~v[14];
        for (int r = 0; r < 12; r++) begin
            for (int g = 0; g < 8; g++) begin
                a = ga[g]; b = gb[g]; c = gc[g]; d = gd[g];
                x = m[SIGMA[r][2*g]];
                y = m[SIGMA[r][2*g+1]];
                v[a] = v[a] + v[b] + x;  v[d] = ror64(v[d] ^ v[a], 32);
                v[c] = v[c] + v[d];      v[b] = ror64(v[b] ^ v[c], 24);
                v[a] = v[a] + v[b] + y;  v[d] = ror64(v[d] ^ v[a], 16);
                v[c] = v[c] + v[d];      v[b] = ror64(v[b] ^ v[c], 63);
            end
        end
        for (int i = 0; i < 8; i++) h[i] ^= v[i] ^ v[i+8];
        return h;
    endfunction

    function automatic logic [3:0][63:0] nonce_hash(input logic [3:0][63:0] seed,
                                                    input logic [3:0][63:0] msg,
                                                    input logic [63:0] nonce,
                                                    input logic [63:0] height);
        logic [15:0][63:0] m;
        logic [7:0][63:0]  d;
        logic [3:0][63:0]  acc, base;
        logic [31:0]       lane;
        acc = '0;
        for (int rnd = 0; rnd < MIX_ROUNDS_DEF; rnd++) begin
            m = '0;
            m[3:0] = seed;
            m[4] = nonce;
            m[5] = height;
            m[6] = 64'(rnd);
            d = b2b_block(m, 52, 32);
            lane = d[0][31:0] % lane_cnt_q;
            m = '0;
            m[3:0] = dag_seed_q;
            m[4] = 64'(lane >> 1);
            d = b2b_block(m, 40, 64);
            acc ^= lane[0] ? d[7:4] : d[3:0];
        end
        m = '0;
        m[3:0] = seed; m[7:4] = msg; m[8] = nonce; m[9] = height;
        d = b2b_block(m, 80, 32);
        base = d[3:0];
        m = '0;
        m[3:0] = acc;
        d = b2b_block(m, 32, 32);
        m = '0;
        m[3:0] = base; m[7:4] = d[3:0]; m[8] = nonce; m[9] = height;
        d = b2b_block(m, 80, 32);
        return d[3:0];
    endfunction

    function automatic t_out nonce_search_predict(input t_in x);
        t_out             r;
        logic [3:0][63:0] msg, tgt, seed, h;
        logic [7:0][63:0] d;
        logic [15:0][63:0] m;
        logic [255:0]     hv, tv;
        logic [63:0]      nonce, tries;
        msg = {x.message_w3, x.message_w2, x.message_w1, x.message_w0};
        tgt = {x.target_w3, x.target_w2, x.target_w1, x.target_w0};
        m = '0;
        m[3:0] = msg;
        d = b2b_block(m, 32, 32);
        seed = d[3:0];
        nonce = x.start_nonce;
        tries = x.max_tries;
        h = '0;
        r = '0;
        if (lane_cnt_q == 0) begin
            nonce += tries;
            tries = 0;
        end
        tv = {<<8{tgt}};
        while (tries != 0) begin
            h = nonce_hash(seed, msg, nonce, x.block_height);
            tries--;
            hv = {<<8{h}};
            if (hv <= tv) begin
                r.found = 1;
                break;
            end
            nonce++;
        end
        r.found_nonce = nonce;
        {r.hash_w3, r.hash_w2, r.hash_w1, r.hash_w0} = h;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic compare_field(input string nm, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            $display("%0t %s: expected %h, actual %h", $time, nm, e, a);
            errors++;
        end
    endtask

    task automatic compare_result(input t_out e, input t_out a);
        compare_field("found", 64'(e.found), 64'(a.found));
        compare_field("found_nonce", e.found_nonce, a.found_nonce);
        compare_field("hash_w0", e.hash_w0, a.hash_w0);
        compare_field("hash_w1", e.hash_w1, a.hash_w1);
        compare_field("hash_w2", e.hash_w2, a.hash_w2);
        compare_field("hash_w3", e.hash_w3, a.hash_w3);
    endtask

    // sampled at the rising edge; inputs move only at the falling edge
    always @(posedge i_clk) begin
        t_tag tag;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("Mismatches found");
            $finish;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            tag = request_tags.pop_front();
            expected_results.push_back(tag.typed ? tag.res : nonce_search_predict(i_in_data));
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result %p", $time, o_out_data);
                errors++;
            end else begin
                compare_result(expected_results.pop_front(), o_out_data);
            end
            n_results++;
            if (o_out_data.found) n_found++;
        end
    end

    // receiver stall: random bursts, one long hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
                i_out_stall = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall = 1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_out_stall = 0;
            end
        end
    end

    // called at a falling edge; drops valid once the transaction is taken
    task automatic send_request(input t_in x, input bit typed, input t_out res);
        t_tag tag;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid = 0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        tag.typed = typed;
        tag.res = res;
        request_tags.push_back(tag);
        i_in_data = x;
        i_in_valid = 1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        i_in_valid = 0;
    endtask

    task automatic drain();
        i_in_valid = 0;
        while (expected_results.size() != 0 || request_tags.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 0;
        if (idx <= CFG_DAG_W3) dag_seed_q[idx] = val;
        else if (idx == CFG_LANES) lane_cnt_q = val[31:0];
    endtask

    task automatic configure(input logic [3:0][63:0] dag, input logic [31:0] lanes);
        drain();
        for (int k = 0; k < 4; k++) cfg_write(CFG_DAG_W0 + 3'(k), dag[k]);
        cfg_write(CFG_LANES, {$urandom, lanes});
        for (logic [3:0] k = 4'(CFG_LANES) + 4'd1; k <= CFG_IDX_MAX; k++)
            cfg_write(k[2:0], rand64());
    endtask

    function automatic t_in random_request(input int kind);
        t_in x;
        x = {rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
             rand64(), rand64(), rand64(), rand64(), rand64()};
        if (kind < 70) begin
            x.max_tries = 0;
        end else if (kind < 82) begin
            {x.target_w0, x.target_w1, x.target_w2, x.target_w3} = '1;
        end else if (kind < 95) begin
            x.max_tries = $urandom_range(1, 2);
        end else begin
            {x.target_w0, x.target_w1, x.target_w2, x.target_w3} = '0;
            x.max_tries = 1;
        end
        return x;
    endfunction

    initial begin
        t_row             rows[$];
        t_row             row;
        t_out             none;
        logic [3:0][63:0] dag;
        logic [31:0]      lanes;
        none = '0;
        dag_seed_q = '0;
        lane_cnt_q = 1;

        // no tries, all zero and all ones
        row.req = '0; row.lanes = 1; row.typed = 1; row.res = '0;
        rows.push_back(row);
        row.req = '1; row.req.max_tries = '0; row.res.found_nonce = '1;
        rows.push_back(row);
        // target at max: first nonce wins, tries and nonce at max
        row.req = '1; row.typed = 0;
        rows.push_back(row);
        // unreachable target, nonce wraps
        row.req = '0; row.req.start_nonce = '1; row.req.max_tries = 2;
        rows.push_back(row);
        row.req = random_request(90);
        rows.push_back(row);
        // zero lane count: nonce advances without hashing
        for (int i = 0; i < 4; i++) begin
            row.req = random_request(i == 0 ? 70 : 90);
            if (i == 1) row.req.max_tries = '1;
            row.lanes = 0; row.typed = 1; row.res = '0;
            row.res.found_nonce = row.req.start_nonce + row.req.max_tries;
            rows.push_back(row);
        end
        // widest lane count, all-ones DAG seed
        for (int i = 0; i < 3; i++) begin
            row.req = random_request(i == 0 ? 75 : 90);
            row.lanes = '1; row.typed = 0;
            rows.push_back(row);
        end

        repeat (7) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].lanes != lane_cnt_q)
                configure(rows[i].lanes == '1 ? '1 : '0, rows[i].lanes);
            send_request(rows[i].req, rows[i].typed, rows[i].res);
        end

        for (int ph = 0; ph < 4; ph++) begin
            dag = {rand64(), rand64(), rand64(), rand64()};
            case (ph)
                0: lanes = $urandom_range(1, 16);
                1: lanes = 0;
                2: lanes = $urandom;
                default: lanes = $urandom_range(1, 3);
            endcase
            if (lanes == 0 && ph != 1) lanes = 1;
            configure(dag, lanes);
            if (ph == 1) hold_req = 1;
            if (ph == 3) quiet = 1;
            for (int i = 0; i < 72; i++)
                send_request(random_request($urandom_range(0, 99)), 0, none);
        end

        drain();
        $display("Run covered %0d results (%0d with a winning nonce) over four lane settings,",
                 n_results, n_found);
        $display("including zero and full lane counts, spare register writes and a long hold.");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
